### rtl/core/lppp_pkg.sv
package lppp_pkg;

	localparam int IMAGE_DIM_MAX = 4096;
	localparam logic [12:0] DIM_CAP = 13'((IMAGE_DIM_MAX < 4096) ? IMAGE_DIM_MAX : 4096);
	localparam int DIV_BITS = 13;
	// depth in Q.16 at or below this is rejected (10*Z <= 65536)
	localparam logic signed [35:0] NEAR_Z_MAX = 36'sd6553;

	typedef enum logic [2:0] {
		REG_ROT_X  = 3'd0,
		REG_ROT_Y  = 3'd1,
		REG_ROT_Z  = 3'd2,
		REG_TRANS  = 3'd3,
		REG_FOCAL  = 3'd4,
		REG_CENTER = 3'd5,
		REG_WIDTH  = 3'd6,
		REG_HEIGHT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_VISIBLE  = 2'd0,
		ST_NONFIN   = 2'd1,
		ST_NEAR     = 2'd2,
		ST_OUTSIDE  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} color_t;

	typedef struct packed {
		status_t     status;
		color_t      color;
		logic [44:0] d;
		logic [62:0] ru;
		logic [62:0] rv;
		logic [12:0] qu;
		logic [12:0] qv;
	} div_t;

	function automatic logic [7:0] ramp(input logic [14:0] a);
		logic [23:0] t;
		begin
			t = 24'(a) * 24'd255 + 24'd8192;
			ramp = t[21:14];
		end
	endfunction

endpackage

### rtl/core/lidar_point_pinhole_projector_core.sv
// Pipeline: 4 math stages, 13 quotient stages, output register.
// Throughput: one point per cycle while the output is not stalled; the
// 13-stage restoring divider takes one quotient bit per stage, so a whole
// stall of the output freezes every stage.
// Reset: arst_n clears all valid bits and loads the default camera setup.
module lidar_point_pinhole_projector_core import lppp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               point_finite,
	input  logic [15:0]        intensity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        pixel_u,
	output logic [11:0]        pixel_v,
	output logic [7:0]         color_blue,
	output logic [7:0]         color_green,
	output logic [7:0]         color_red,
	output logic [1:0]         status
);

	logic [53:0] rot_x_q, rot_y_q, rot_z_q;
	logic [59:0] trans_q;
	logic [47:0] focal_q;
	logic [39:0] center_q;
	logic [12:0] width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q  <= 54'd65536;
			rot_y_q  <= 54'd65536 << 18;
			rot_z_q  <= 54'd65536 << 36;
			trans_q  <= '0;
			focal_q  <= {24'd307200, 24'd307200};
			center_q <= {20'd153600, 20'd245760};
			width_q  <= 13'd1920;
			height_q <= 13'd1200;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROT_X:  rot_x_q  <= cfg_data[53:0];
				REG_ROT_Y:  rot_y_q  <= cfg_data[53:0];
				REG_ROT_Z:  rot_z_q  <= cfg_data[53:0];
				REG_TRANS:  trans_q  <= cfg_data[59:0];
				REG_FOCAL:  focal_q  <= cfg_data[47:0];
				REG_CENTER: center_q <= cfg_data[39:0];
				REG_WIDTH:  width_q  <= cfg_data[12:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	logic [12:0] w_lim, h_lim;
	assign w_lim = (width_q > DIM_CAP) ? DIM_CAP : width_q;
	assign h_lim = (height_q > DIM_CAP) ? DIM_CAP : height_q;

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---- stage 1: nine rotation products, colormap
	logic signed [49:0] m_s1 [9];
	logic               v_s1;
	status_t            st_s1;
	color_t             col_s1;

	logic signed [17:0] coef [9];
	logic signed [31:0] pin [3];
	logic [14:0]        up_a, dn_a;
	color_t             col_c;

	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			coef[j]     = rot_x_q[18*j +: 18];
			coef[3 + j] = rot_y_q[18*j +: 18];
			coef[6 + j] = rot_z_q[18*j +: 18];
		end
	end

	assign up_a = {1'b0, intensity[13:0]};
	assign dn_a = 15'd16384 - {1'b0, intensity[13:0]};

	always_comb begin
		case (intensity[15:14])
			2'd0:    col_c = '{b: 8'd0,       g: ramp(up_a), r: 8'd255};
			2'd1:    col_c = '{b: 8'd0,       g: 8'd255,     r: ramp(dn_a)};
			2'd2:    col_c = '{b: ramp(up_a), g: 8'd255,     r: 8'd0};
			default: col_c = '{b: 8'd255,     g: ramp(dn_a), r: 8'd0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++)
				m_s1[k] <= coef[k] * pin[k % 3];
			st_s1  <= point_finite ? ST_VISIBLE : ST_NONFIN;
			col_s1 <= col_c;
		end
	end

	// ---- stage 2: sums with translation, floor to Q.16
	logic signed [35:0] x_s2, y_s2, z_s2;
	logic               v_s2;
	status_t            st_s2;
	color_t             col_s2;

	logic signed [51:0] acc [3];
	always_comb begin
		for (int a = 0; a < 3; a++)
			acc[a] = 52'(m_s1[3*a]) + 52'(m_s1[3*a + 1]) + 52'(m_s1[3*a + 2])
				+ (52'($signed(trans_q[20*a +: 20])) <<< 16);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2   <= 36'(acc[0] >>> 16);
			y_s2   <= 36'(acc[1] >>> 16);
			z_s2   <= 36'(acc[2] >>> 16);
			st_s2  <= st_s1;
			col_s2 <= col_s1;
		end
	end

	// ---- stage 3: near-plane test, projection products
	logic signed [60:0] fxx_s3, fyy_s3;
	logic signed [56:0] cxz_s3, cyz_s3;
	logic signed [49:0] wz_s3, hz_s3;
	logic signed [35:0] z_s3;
	logic               v_s3;
	status_t            st_s3;
	color_t             col_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			fxx_s3 <= $signed({1'b0, focal_q[23:0]}) * x_s2;
			fyy_s3 <= $signed({1'b0, focal_q[47:24]}) * y_s2;
			cxz_s3 <= $signed({1'b0, center_q[19:0]}) * z_s2;
			cyz_s3 <= $signed({1'b0, center_q[39:20]}) * z_s2;
			wz_s3  <= $signed({1'b0, w_lim}) * z_s2;
			hz_s3  <= $signed({1'b0, h_lim}) * z_s2;
			z_s3   <= z_s2;
			if (st_s2 == ST_VISIBLE && z_s2 <= NEAR_Z_MAX)
				st_s3 <= ST_NEAR;
			else
				st_s3 <= st_s2;
			col_s3 <= col_s2;
		end
	end

	// ---- stage 4: bounds test, divider operands
	div_t               d_s4;
	logic               v_s4;
	logic signed [61:0] nu, nv;
	logic signed [63:0] num_u, num_v;
	logic               outside;
	status_t            st_c;

	assign nu = 62'(fxx_s3) + 62'(cxz_s3);
	assign nv = 62'(fyy_s3) + 62'(cyz_s3);
	assign outside = nu < 0 || nu >= (62'(wz_s3) <<< 8)
		|| nv < 0 || nv >= (62'(hz_s3) <<< 8);
	assign num_u = (64'(nu) <<< 1) + (64'(z_s3) <<< 8);
	assign num_v = (64'(nv) <<< 1) + (64'(z_s3) <<< 8);
	assign st_c = (st_s3 == ST_VISIBLE && outside) ? ST_OUTSIDE : st_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s4.status <= st_c;
			d_s4.color  <= col_s3;
			d_s4.d      <= {z_s3[35:0], 9'd0};
			d_s4.ru     <= num_u[62:0];
			d_s4.rv     <= num_v[62:0];
			d_s4.qu     <= '0;
			d_s4.qv     <= '0;
		end
	end

	// ---- quotient stages: one bit each, MSB first
	div_t dstg [DIV_BITS];
	logic [DIV_BITS-1:0] v_div;

	function automatic div_t div_step(input div_t src, input int k);
		div_t        r;
		logic [62:0] sh;
		r  = src;
		sh = 63'(src.d) << (DIV_BITS - 1 - k);
		if (src.ru >= sh) begin
			r.ru = src.ru - sh;
			r.qu = src.qu | (13'd1 << (DIV_BITS - 1 - k));
		end
		if (src.rv >= sh) begin
			r.rv = src.rv - sh;
			r.qv = src.qv | (13'd1 << (DIV_BITS - 1 - k));
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			dstg[0] <= div_step(d_s4, 0);
			for (int k = 1; k < DIV_BITS; k++)
				dstg[k] <= div_step(dstg[k-1], k);
		end
	end

	// ---- output register: clamp to the last column/row, blank non-visible
	div_t        fin;
	logic [12:0] pu_c, pv_c;
	assign fin  = dstg[DIV_BITS-1];
	assign pu_c = (fin.qu > w_lim - 13'd1) ? w_lim - 13'd1 : fin.qu;
	assign pv_c = (fin.qv > h_lim - 13'd1) ? h_lim - 13'd1 : fin.qv;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fin.status == ST_VISIBLE) begin
				pixel_u     <= pu_c[11:0];
				pixel_v     <= pv_c[11:0];
				color_blue  <= fin.color.b;
				color_green <= fin.color.g;
				color_red   <= fin.color.r;
			end else begin
				pixel_u     <= '0;
				pixel_v     <= '0;
				color_blue  <= '0;
				color_green <= '0;
				color_red   <= '0;
			end
			status <= fin.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_div     <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_div     <= {v_div[DIV_BITS-2:0], v_s4};
			out_valid <= v_div[DIV_BITS-1];
		end
	end

endmodule

### rtl/core/lppp_checker.sv
module lppp_checker import lppp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] pixel_u,
	input logic [11:0] pixel_v,
	input logic [7:0]  color_blue,
	input logic [7:0]  color_green,
	input logic [7:0]  color_red,
	input logic [1:0]  status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("output beat dropped while stalled");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_VISIBLE |-> pixel_u == 12'd0 && pixel_v == 12'd0
			&& color_blue == 8'd0 && color_green == 8'd0 && color_red == 8'd0)
		else $error("rejected point carries pixel or color");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_VISIBLE |->
			color_red == 8'd255 || color_green == 8'd255 || color_blue == 8'd255)
		else $error("colormap lost its saturated channel");

	a_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_VISIBLE |-> color_red == 8'd0 || color_blue == 8'd0)
		else $error("colormap mixes red and blue");

endmodule

bind lidar_point_pinhole_projector_core lppp_checker u_lppp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_u     (pixel_u),
	.pixel_v     (pixel_v),
	.color_blue  (color_blue),
	.color_green (color_green),
	.color_red   (color_red),
	.status      (status)
);
